// ===== rtl/core/sag_pkg.sv =====
// ============================================================================
// sag_pkg - sliding attack generator shared definitions
// Action codes, board masks, stage word types and board permutations.
// ============================================================================
package sag_pkg;

    localparam logic [2:0] ACT_ROOK   = 3'd0;
    localparam logic [2:0] ACT_BISHOP = 3'd1;
    localparam logic [2:0] ACT_QUEEN  = 3'd2;
    localparam logic [2:0] ACT_FILE   = 3'd3;
    localparam logic [2:0] ACT_PAWN_W = 3'd4;
    localparam logic [2:0] ACT_PAWN_B = 3'd5;

    localparam logic [63:0] FILE_A_MASK = 64'h0101010101010101;
    localparam logic [63:0] FILE_H_MASK = 64'h8080808080808080;
    localparam logic [63:0] MAIN_DIAG   = 64'h8040201008040201;
    localparam logic [63:0] MAIN_ANTI   = 64'h0102040810204080;

    // line slots; the rank line is solved on the transposed board
    localparam int NUM_LINES = 4;
    localparam int LINE_FILE = 0;
    localparam int LINE_RANK = 1;
    localparam int LINE_DIAG = 2;
    localparam int LINE_ANTI = 3;

    typedef struct packed {
        logic [63:0] fw;    // occupancy on the line
        logic [63:0] rv;    // same, ranks swapped
        logic [63:0] s;     // slider bit
        logic [63:0] m;     // line mask without slider bit
    } line_setup_t;

    typedef struct packed {
        logic [2:0]                        action;
        logic [63:0]                       pawn;
        line_setup_t [NUM_LINES-1:0]       line;
    } s1_word_t;

    typedef struct packed {
        logic [63:0] fw_d;
        logic [63:0] rv_d;
        logic [63:0] m;
    } line_diff_t;

    typedef struct packed {
        logic [2:0]                        action;
        logic [63:0]                       pawn;
        line_diff_t [NUM_LINES-1:0]        line;
    } s2_word_t;

    // vertical flip: rank r goes to rank 7-r
    function automatic logic [63:0] swap_ranks(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) begin
            y[i] = x[i ^ 56];
        end
        return y;
    endfunction

    // flip about the a1-h8 diagonal: (rank, file) -> (file, rank)
    function automatic logic [63:0] transpose(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) begin
            y[i] = x[((i & 7) << 3) | (i >> 3)];
        end
        return y;
    endfunction

endpackage

// ===== rtl/core/sag_stage_mask.sv =====
// ============================================================================
// sag_stage_mask - line mask stage
// Builds slider bit and line masks for all four lines, masks occupancy and
// computes the pawn-set shifts; registers the result.
// ============================================================================
module sag_stage_mask
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        action,
    input  logic [63:0]       board,
    input  logic [2:0]        file_index,
    input  logic [2:0]        rank_index,
    output logic              out_valid,
    input  logic              out_ready,
    output sag_pkg::s1_word_t out_data
);

    logic              valid_reg;
    sag_pkg::s1_word_t data_reg;
    sag_pkg::s1_word_t data_next;

    always_comb
    begin
        logic [63:0] occ_t;
        logic [63:0] s_f;
        logic [63:0] s_t;
        logic [63:0] m_diag;
        logic [63:0] m_anti;
        logic [2:0]  d;
        logic [3:0]  c;
        logic [2:0]  e;

        occ_t = sag_pkg::transpose(board);
        s_f   = 64'd1 << {rank_index, file_index};
        s_t   = 64'd1 << {file_index, rank_index};

        if (file_index >= rank_index)
        begin
            d      = file_index - rank_index;
            m_diag = sag_pkg::MAIN_DIAG >> {d, 3'b000};
        end
        else
        begin
            d      = rank_index - file_index;
            m_diag = sag_pkg::MAIN_DIAG << {d, 3'b000};
        end

        c = {1'b0, file_index} + {1'b0, rank_index};
        if (c >= 4'd7)
        begin
            e      = 3'(c - 4'd7);
            m_anti = sag_pkg::MAIN_ANTI << {e, 3'b000};
        end
        else
        begin
            e      = 3'(4'd7 - c);
            m_anti = sag_pkg::MAIN_ANTI >> {e, 3'b000};
        end

        data_next.action = action;

        data_next.line[sag_pkg::LINE_FILE].s = s_f;
        data_next.line[sag_pkg::LINE_FILE].m = (sag_pkg::FILE_A_MASK << file_index) & ~s_f;
        data_next.line[sag_pkg::LINE_FILE].fw = board & data_next.line[sag_pkg::LINE_FILE].m;

        data_next.line[sag_pkg::LINE_RANK].s = s_t;
        data_next.line[sag_pkg::LINE_RANK].m = (sag_pkg::FILE_A_MASK << rank_index) & ~s_t;
        data_next.line[sag_pkg::LINE_RANK].fw = occ_t & data_next.line[sag_pkg::LINE_RANK].m;

        data_next.line[sag_pkg::LINE_DIAG].s = s_f;
        data_next.line[sag_pkg::LINE_DIAG].m = m_diag & ~s_f;
        data_next.line[sag_pkg::LINE_DIAG].fw = board & data_next.line[sag_pkg::LINE_DIAG].m;

        data_next.line[sag_pkg::LINE_ANTI].s = s_f;
        data_next.line[sag_pkg::LINE_ANTI].m = m_anti & ~s_f;
        data_next.line[sag_pkg::LINE_ANTI].fw = board & data_next.line[sag_pkg::LINE_ANTI].m;

        for (int i = 0; i < sag_pkg::NUM_LINES; i++)
        begin
            data_next.line[i].rv = sag_pkg::swap_ranks(data_next.line[i].fw);
        end

        if (action == sag_pkg::ACT_PAWN_W)
        begin
            data_next.pawn = ((board << 9) & ~sag_pkg::FILE_A_MASK)
                           | ((board << 7) & ~sag_pkg::FILE_H_MASK);
        end
        else
        begin
            data_next.pawn = ((board >> 7) & ~sag_pkg::FILE_A_MASK)
                           | ((board >> 9) & ~sag_pkg::FILE_H_MASK);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/sag_stage_sub.sv =====
// ============================================================================
// sag_stage_sub - hyperbola subtraction stage
// Subtracts the slider bit from the forward and flipped line occupancy of
// every line in parallel; registers the differences.
// ============================================================================
module sag_stage_sub
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sag_pkg::s1_word_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sag_pkg::s2_word_t out_data
);

    logic              valid_reg;
    sag_pkg::s2_word_t data_reg;
    sag_pkg::s2_word_t data_next;

    always_comb
    begin
        data_next.action = in_data.action;
        data_next.pawn   = in_data.pawn;
        for (int i = 0; i < sag_pkg::NUM_LINES; i++)
        begin
            data_next.line[i].fw_d = in_data.line[i].fw - in_data.line[i].s;
            data_next.line[i].rv_d = in_data.line[i].rv
                                   - sag_pkg::swap_ranks(in_data.line[i].s);
            data_next.line[i].m    = in_data.line[i].m;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/sag_stage_merge.sv =====
// ============================================================================
// sag_stage_merge - line merge and action select stage
// Folds each line's two differences, transposes the rank line back and
// selects the attack set by action; holds the output register.
// ============================================================================
module sag_stage_merge
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sag_pkg::s2_word_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [63:0]       attacks
);

    logic        valid_reg;
    logic [63:0] attacks_reg;
    logic [63:0] attacks_next;
    logic [63:0] res [sag_pkg::NUM_LINES];
    logic [63:0] res_rank;

    always_comb
    begin
        for (int i = 0; i < sag_pkg::NUM_LINES; i++)
        begin
            res[i] = (in_data.line[i].fw_d ^ sag_pkg::swap_ranks(in_data.line[i].rv_d))
                   & in_data.line[i].m;
        end
        res_rank = sag_pkg::transpose(res[sag_pkg::LINE_RANK]);

        unique case (in_data.action) inside
            sag_pkg::ACT_ROOK:
                attacks_next = res[sag_pkg::LINE_FILE] | res_rank;
            sag_pkg::ACT_BISHOP:
                attacks_next = res[sag_pkg::LINE_DIAG] | res[sag_pkg::LINE_ANTI];
            sag_pkg::ACT_QUEEN:
                attacks_next = res[sag_pkg::LINE_FILE] | res_rank
                             | res[sag_pkg::LINE_DIAG] | res[sag_pkg::LINE_ANTI];
            sag_pkg::ACT_FILE:
                attacks_next = res[sag_pkg::LINE_FILE];
            sag_pkg::ACT_PAWN_W, sag_pkg::ACT_PAWN_B:
                attacks_next = in_data.pawn;
            default:
                attacks_next = 64'd0;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            attacks_reg <= attacks_next;
        end
    end

    assign out_valid = valid_reg;
    assign attacks   = attacks_reg;

    // white pawn set never lands on the first rank
    a_pawn_w_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.action == sag_pkg::ACT_PAWN_W)
        |=> (attacks_reg[7:0] == 8'd0))
        else $error("white pawn attacks on first rank");

    // black pawn set never lands on the last rank
    a_pawn_b_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.action == sag_pkg::ACT_PAWN_B)
        |=> (attacks_reg[63:56] == 8'd0))
        else $error("black pawn attacks on last rank");

    // a rook sees at most 14 squares
    a_rook_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.action == sag_pkg::ACT_ROOK)
        |=> ($countones(attacks_reg) <= 14))
        else $error("rook attack set too large");

    // a bishop sees at most 13 squares
    a_bishop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.action == sag_pkg::ACT_BISHOP)
        |=> ($countones(attacks_reg) <= 13))
        else $error("bishop attack set too large");

    // unused action codes give an empty set
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.action > sag_pkg::ACT_PAWN_B)
        |=> (attacks_reg == 64'd0))
        else $error("unused action gave attacks");

endmodule

// ===== rtl/core/sliding_attack_generator.sv =====
// ============================================================================
// sliding_attack_generator - bitboard attack set generator
// Rook, bishop, queen, file-only and pawn-set attacks on 64-bit boards.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one word: action, board,
//   file_index, rank_index. Output channel (out_valid/out_ready) carries
//   the attack set for that word, bit rank*8+file, in input order.
//   There are three register stages: mask build, line subtraction,
//   merge/select. The first of them loads at the accepting edge, and
//   out_valid rises once the merge/select register holds the word.
//   Throughput is one word per cycle while out_ready stays high.
//   Each stage takes a new word when it is empty or its word moves on, so
//   bubbles close up; when out_ready stays low the pipeline fills and
//   in_ready drops after three words are held. Nothing is lost or repeated.
//   Reset (rst_n low) empties every stage; no configuration, no state
//   between words.
// ============================================================================
module sliding_attack_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [63:0] board,
    input  logic [2:0]  file_index,
    input  logic [2:0]  rank_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] attacks
);

    logic              s1_valid;
    logic              s1_ready;
    sag_pkg::s1_word_t s1_data;
    logic              s2_valid;
    logic              s2_ready;
    sag_pkg::s2_word_t s2_data;

    sag_stage_mask u_mask
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .board      (board),
        .file_index (file_index),
        .rank_index (rank_index),
        .out_valid  (s1_valid),
        .out_ready  (s1_ready),
        .out_data   (s1_data)
    );

    sag_stage_sub u_sub
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    sag_stage_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .attacks   (attacks)
    );

endmodule

// ===== test/sliding_attack_generator_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sliding_attack_generator_tb - attack set generator testbench
// Drives boards, squares and every action code through the valid/ready input
// with random gaps and output stalls. Each attack set is predicted by walking
// rays from the square until the first blocker, or by shifting pawn sets, and
// is compared in order with what the block returns.
// ============================================================================
module sliding_attack_generator_tb;

    // codes the block leaves unused; they must give an empty set
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam int RANDOM_WORDS   = 1230;
    localparam int MAX_GAP        = 18;
    localparam int LONG_HOLD      = 150;
    localparam int HOLD_AT        = 300;   // results seen before the long hold
    localparam int FLOOD_LO       = 280;   // sender gives no gaps in this window
    localparam int FLOOD_HI       = 420;
    localparam int DRAIN_AT       = 700;   // random word index of the drain pause
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1500;

    class attack_scoreboard;
        logic [63:0] expected_attacks[$];
        int          words_in;
        int          words_checked;
        int          mismatches;
        int          action_hits[8];

        // squares hit walking from (f, r) in one direction, first blocker included
        function logic [63:0] walk_ray(logic [63:0] occ, int f, int r, int df, int dr);
            logic [63:0] hits;
            int          x;
            int          y;
            bit          blocked;
            hits    = '0;
            x       = f + df;
            y       = r + dr;
            blocked = 1'b0;
            while (!blocked && x >= 0 && x < 8 && y >= 0 && y < 8) begin
                hits[y * 8 + x] = 1'b1;
                blocked = occ[y * 8 + x];
                x += df;
                y += dr;
            end
            return hits;
        endfunction

        function logic [63:0] predict_attacks(logic [2:0] act, logic [63:0] occ,
                                              logic [2:0] fi, logic [2:0] ri);
            logic [63:0] straight;
            logic [63:0] diagonal;
            logic [63:0] vertical;
            int          f;
            int          r;
            f        = int'(fi);
            r        = int'(ri);
            vertical = walk_ray(occ, f, r, 0, 1) | walk_ray(occ, f, r, 0, -1);
            straight = vertical | walk_ray(occ, f, r, 1, 0) | walk_ray(occ, f, r, -1, 0);
            diagonal = walk_ray(occ, f, r, 1, 1) | walk_ray(occ, f, r, -1, -1)
                     | walk_ray(occ, f, r, 1, -1) | walk_ray(occ, f, r, -1, 1);
            case (act)
                sag_pkg::ACT_ROOK:   return straight;
                sag_pkg::ACT_BISHOP: return diagonal;
                sag_pkg::ACT_QUEEN:  return straight | diagonal;
                sag_pkg::ACT_FILE:   return vertical;
                sag_pkg::ACT_PAWN_W:
                    return ((occ << 9) & ~sag_pkg::FILE_A_MASK)
                         | ((occ << 7) & ~sag_pkg::FILE_H_MASK);
                sag_pkg::ACT_PAWN_B:
                    return ((occ >> 7) & ~sag_pkg::FILE_A_MASK)
                         | ((occ >> 9) & ~sag_pkg::FILE_H_MASK);
                default:             return '0;
            endcase
        endfunction

        function void note_word(logic [2:0] act, logic [63:0] occ,
                                logic [2:0] fi, logic [2:0] ri);
            expected_attacks.push_back(predict_attacks(act, occ, fi, ri));
            action_hits[act]++;
            words_in++;
        endfunction

        function void check_word(logic [63:0] got);
            logic [63:0] want;
            if (expected_attacks.size() == 0) begin
                $error("attacks: result %h arrived with nothing outstanding", got);
                mismatches++;
            end else begin
                want = expected_attacks.pop_front();
                if (got !== want) begin
                    $error("attacks mismatch: expected %h, actual %h", want, got);
                    mismatches++;
                end
            end
            words_checked++;
        endfunction

        function int pending();
            return expected_attacks.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  action;
    logic [63:0] board;
    logic [2:0]  file_index;
    logic [2:0]  rank_index;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] attacks;

    attack_scoreboard sb = new();
    int               sent;
    int               idle_cycles;

    sliding_attack_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .board      (board),
        .file_index (file_index),
        .rank_index (rank_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .attacks    (attacks)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // handshake monitor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_word(action, board, file_index, rank_index);
            if (out_valid && out_ready)
                sb.check_word(attacks);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("sliding_attack_generator verification failed");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [2:0] a, input logic [63:0] b,
                             input logic [2:0] f, input logic [2:0] r);
        int gap;
        if ((sent >= FLOOD_LO && sent < FLOOD_HI) || (sent / 64) % 4 == 3)
            gap = 0;
        else
            gap = $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= a;
        board      <= b;
        file_index <= f;
        rank_index <= r;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    function automatic logic [63:0] rand_board();
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0:       return a;
            1, 2:    return a & b & c;         // sparse: long rays
            3:       return a & b;
            4:       return a | b;              // dense: short rays
            5:       return (64'h1 << $urandom_range(0, 63)) | (64'h1 << $urandom_range(0, 63));
            default: return $urandom_range(0, 1) ? ~(a & b & c) : '0;
        endcase
    endfunction

    // result side: random stalls, one long hold to back up the pipeline
    initial begin
        int got;
        int stall;
        got       = 0;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (got == HOLD_AT)
                stall = LONG_HOLD;
            else if ((got / 96) % 3 == 1)
                stall = 0;
            else
                stall = $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                if (out_ready)
                    out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got++;
        end
    end

    initial begin
        sent        = 0;
        idle_cycles = 0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        action     <= sag_pkg::ACT_ROOK;
        board      <= '0;
        file_index <= '0;
        rank_index <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // every action code on an empty board from the a1 corner
        for (int a = 0; a < 8; a++)
            send_word(3'(a), '0, 3'd0, 3'd0);
        send_word(sag_pkg::ACT_ROOK,   '1, 3'd7, 3'd7);
        send_word(sag_pkg::ACT_BISHOP, '1, 3'd7, 3'd0);
        // only own square set
        send_word(sag_pkg::ACT_QUEEN,  64'h1 << (4 * 8 + 3), 3'd3, 3'd4);
        send_word(sag_pkg::ACT_FILE,   '0, 3'd5, 3'd2);
        send_word(sag_pkg::ACT_QUEEN,  '1, 3'd0, 3'd7);
        send_word(sag_pkg::ACT_QUEEN,  64'hAA55_AA55_AA55_AA55, 3'd4, 3'd3);
        send_word(sag_pkg::ACT_ROOK,   ~(64'h1 << (5 * 8 + 2)), 3'd2, 3'd5);
        send_word(sag_pkg::ACT_BISHOP, 64'h0000_0000_0000_0000, 3'd3, 3'd3);
        send_word(sag_pkg::ACT_PAWN_W, '1, 3'd6, 3'd1);
        // h file with last rank, a file with first rank
        send_word(sag_pkg::ACT_PAWN_W, 64'hFF80_8080_8080_8080, 3'd0, 3'd0);
        send_word(sag_pkg::ACT_PAWN_B, '1, 3'd7, 3'd7);
        send_word(sag_pkg::ACT_PAWN_B, 64'h0101_0101_0101_01FF, 3'd2, 3'd6);
        send_word(ACT_SPARE_6,         '1, 3'd7, 3'd7);
        send_word(ACT_SPARE_7,         '1, 3'd5, 3'd3);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == DRAIN_AT) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (sb.pending() != 0);
            end
            send_word(3'($urandom_range(0, 7)), rand_board(),
                      3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d words: rook %0d bishop %0d queen %0d file %0d",
                 sb.words_in, sb.action_hits[sag_pkg::ACT_ROOK],
                 sb.action_hits[sag_pkg::ACT_BISHOP], sb.action_hits[sag_pkg::ACT_QUEEN],
                 sb.action_hits[sag_pkg::ACT_FILE]);
        $display("  pawn %0d/%0d spare %0d; %0d attack sets checked, %0d mismatches",
                 sb.action_hits[sag_pkg::ACT_PAWN_W], sb.action_hits[sag_pkg::ACT_PAWN_B],
                 sb.action_hits[ACT_SPARE_6] + sb.action_hits[ACT_SPARE_7],
                 sb.words_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("sliding_attack_generator verification clean");
        else
            $display("sliding_attack_generator verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sag_pkg.sv
rtl/core/sag_stage_mask.sv
rtl/core/sag_stage_sub.sv
rtl/core/sag_stage_merge.sv
rtl/core/sliding_attack_generator.sv
test/sliding_attack_generator_tb.sv
